@@ hdl/kvd_pkg.sv @@
// Shared types and constants for the key/value record deframer.
// Used by kvd_parser, kvd_out_buf and kv_record_vlq_deframer; depends on nothing.
`default_nettype none

package kvd_pkg;

  // Decoded length width and VLQ layout.
  localparam int LenW         = 32;
  localparam int VlqShift     = 7;
  localparam int VlqMaxBytes  = (LenW + VlqShift - 1) / VlqShift;
  localparam int VlqLastShift = VlqShift * (VlqMaxBytes - 1);
  localparam int VlqLastBits  = LenW - VlqLastShift;
  localparam int CntW         = 3;

  // Result kinds.
  typedef enum logic [1:0] {
    KindKey    = 2'd0,
    KindValue  = 2'd1,
    KindEmpty  = 2'd2,
    KindStatus = 2'd3
  } kind_e;

  // File status codes.
  typedef enum logic [1:0] {
    StClean    = 2'd0,
    StPartial  = 2'd1,
    StTrunc    = 2'd2,
    StOverflow = 2'd3
  } status_e;

  // One payload or empty-record result.
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        payload_byte;
    logic              record_done;
    logic [LenW-1:0]   key_length;
    logic [LenW-1:0]   value_length;
  } rec_t;

  // Everything one input byte produces: an optional record result and an
  // optional file status result, in that order.
  typedef struct packed {
    logic    has_rec;
    rec_t    rec;
    logic    has_stat;
    status_e status;
  } pair_t;

endpackage

`default_nettype wire

@@ hdl/kvd_parser.sv @@
// Record parser: VLQ length decoding, key/value byte tagging and file status.
// Depends on kvd_pkg for types and constants.
`default_nettype none

module kvd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_file_i,
  output kvd_pkg::pair_t     pair_o
);

  typedef enum logic [2:0] {
    PhKeyLen = 3'd0,
    PhValLen = 3'd1,
    PhKey    = 3'd2,
    PhVal    = 3'd3,
    PhSkip   = 3'd4
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [kvd_pkg::LenW-1:0]     acc_q, acc_d;
  logic [kvd_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [kvd_pkg::LenW-1:0]     key_len_q, key_len_d;
  logic [kvd_pkg::LenW-1:0]     val_len_q, val_len_d;
  logic [kvd_pkg::LenW-1:0]     remain_q, remain_d;

  logic [6:0]                   data7;
  logic                         more;
  logic [4:0]                   shamt;
  logic [kvd_pkg::LenW-1:0]     acc_or;
  logic                         over;
  logic [kvd_pkg::LenW-1:0]     remain_dec;

  // Next state and results for the byte being transferred.
  always_comb begin
    data7      = data_byte_i[6:0];
    more       = data_byte_i[7];
    shamt      = 5'(cnt_q) * 5'(kvd_pkg::VlqShift);
    acc_or     = acc_q | (kvd_pkg::LenW'(data7) << shamt);
    over       = (cnt_q == kvd_pkg::CntW'(kvd_pkg::VlqMaxBytes - 1)) &&
                 (((data7 >> kvd_pkg::VlqLastBits) != 7'd0) || more);
    remain_dec = (remain_q != '0) ? remain_q - kvd_pkg::LenW'(1) : '0;

    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    key_len_d = key_len_q;
    val_len_d = val_len_q;
    remain_d  = remain_q;

    pair_o                  = '0;
    pair_o.rec.kind         = kvd_pkg::KindKey;
    pair_o.rec.payload_byte = data_byte_i;
    pair_o.status           = kvd_pkg::StClean;

    case (phase_q)
      PhKeyLen, PhValLen: begin
        pair_o.rec.payload_byte = 8'd0;
        if (over) begin
          phase_d = PhSkip;
        end else if (more) begin
          acc_d = acc_or;
          cnt_d = cnt_q + kvd_pkg::CntW'(1);
        end else begin
          acc_d = '0;
          cnt_d = '0;
          if (phase_q == PhKeyLen) begin
            key_len_d = acc_or;
            phase_d   = PhValLen;
          end else begin
            val_len_d = acc_or;
            if (key_len_q != '0) begin
              phase_d  = PhKey;
              remain_d = key_len_q;
            end else if (acc_or != '0) begin
              phase_d  = PhVal;
              remain_d = acc_or;
            end else begin
              // Both lengths zero: the record completes on its own.
              pair_o.has_rec          = 1'b1;
              pair_o.rec.kind         = kvd_pkg::KindEmpty;
              pair_o.rec.record_done  = 1'b1;
              pair_o.rec.key_length   = key_len_q;
              pair_o.rec.value_length = acc_or;
              phase_d                 = PhKeyLen;
            end
          end
        end
      end
      PhKey: begin
        pair_o.has_rec  = 1'b1;
        pair_o.rec.kind = kvd_pkg::KindKey;
        remain_d        = remain_dec;
        if (remain_dec == '0) begin
          if (val_len_q != '0) begin
            phase_d  = PhVal;
            remain_d = val_len_q;
          end else begin
            pair_o.rec.record_done  = 1'b1;
            pair_o.rec.key_length   = key_len_q;
            pair_o.rec.value_length = val_len_q;
            phase_d                 = PhKeyLen;
          end
        end
      end
      PhVal: begin
        pair_o.has_rec  = 1'b1;
        pair_o.rec.kind = kvd_pkg::KindValue;
        remain_d        = remain_dec;
        if (remain_dec == '0) begin
          pair_o.rec.record_done  = 1'b1;
          pair_o.rec.key_length   = key_len_q;
          pair_o.rec.value_length = val_len_q;
          phase_d                 = PhKeyLen;
        end
      end
      default: begin
        // Ignore everything until end of file.
        pair_o.rec.payload_byte = 8'd0;
      end
    endcase

    // End of file: report status from the updated state, then start over.
    if (end_of_file_i) begin
      pair_o.has_stat = 1'b1;
      if (phase_d == PhKeyLen && cnt_d == '0) begin
        pair_o.status = kvd_pkg::StClean;
      end else if (phase_d == PhKeyLen || phase_d == PhValLen || phase_d == PhKey) begin
        pair_o.status = kvd_pkg::StPartial;
      end else if (phase_d == PhVal) begin
        pair_o.status = kvd_pkg::StTrunc;
      end else begin
        pair_o.status = kvd_pkg::StOverflow;
      end
      phase_d   = PhKeyLen;
      acc_d     = '0;
      cnt_d     = '0;
      key_len_d = '0;
      val_len_d = '0;
      remain_d  = '0;
    end
  end

  // Parser state advances on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhKeyLen;
      acc_q     <= '0;
      cnt_q     <= '0;
      key_len_q <= '0;
      val_len_q <= '0;
      remain_q  <= '0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      key_len_q <= key_len_d;
      val_len_q <= val_len_d;
      remain_q  <= remain_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/kvd_out_buf.sv @@
// Result register: holds up to two results of one input byte and sends them
// out one per cycle unless stalled. Depends on kvd_pkg for the result types.
`default_nettype none

module kvd_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire kvd_pkg::pair_t  pair_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [1:0]           kind_o,
  output logic [7:0]           payload_byte_o,
  output logic                 record_done_o,
  output logic [31:0]          key_length_o,
  output logic [31:0]          value_length_o,
  output logic [1:0]           status_o,
  output logic                 final_res_o
);

  logic              pend_rec_q, pend_rec_d;
  logic              pend_stat_q, pend_stat_d;
  kvd_pkg::rec_t     rec_q;
  kvd_pkg::status_e  stat_q;
  logic              take;

  // The buffer frees up when it is empty or its last result transfers now.
  always_comb begin
    take        = out_valid_o && !out_stall_i;
    free_o      = !(pend_rec_q || pend_stat_q) || (take && !(pend_rec_q && pend_stat_q));
    pend_rec_d  = pend_rec_q;
    pend_stat_d = pend_stat_q;
    if (load_i) begin
      pend_rec_d  = pair_i.has_rec;
      pend_stat_d = pair_i.has_stat;
    end else if (take) begin
      if (pend_rec_q) begin
        pend_rec_d = 1'b0;
      end else begin
        pend_stat_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_rec_q  <= 1'b0;
      pend_stat_q <= 1'b0;
    end else begin
      pend_rec_q  <= pend_rec_d;
      pend_stat_q <= pend_stat_d;
    end
  end

  // Result payload is captured with the pending flags.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q  <= pair_i.rec;
      stat_q <= pair_i.status;
    end
  end

  // The record result goes first, the status result after it.
  always_comb begin
    out_valid_o = pend_rec_q || pend_stat_q;
    if (pend_rec_q) begin
      kind_o         = rec_q.kind;
      payload_byte_o = rec_q.payload_byte;
      record_done_o  = rec_q.record_done;
      key_length_o   = 32'(rec_q.key_length);
      value_length_o = 32'(rec_q.value_length);
      status_o       = kvd_pkg::StClean;
      final_res_o    = !pend_stat_q;
    end else begin
      kind_o         = kvd_pkg::KindStatus;
      payload_byte_o = 8'd0;
      record_done_o  = 1'b0;
      key_length_o   = 32'd0;
      value_length_o = 32'd0;
      status_o       = stat_q;
      final_res_o    = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/kv_record_vlq_deframer.sv @@
// Top level of the key/value snapshot deframer.
// Depends on kvd_pkg, kvd_parser and kvd_out_buf.
//
// Usage: file bytes enter on the input channel (in_valid_i, in_stall_o,
// data_byte_i, end_of_file_i), one byte per transfer, with end_of_file_i
// high on the last byte of a file. Results leave on the output channel
// (out_valid_o, out_stall_i and the result fields). Key and value bytes come
// out tagged by kind; the last payload byte of a record, or a result of its
// own for an empty record, carries record_done_o and both lengths. After the
// end-of-file byte a status result follows and the parser starts a new file.
// final_res_o marks the last result that one input byte produces.
// The first result of an input transfer is registered and goes out in the
// next cycle. The block takes one byte per cycle when not stalled; the parser
// state update is a single pass of VLQ shift-and-OR and a 32-bit down count.
// Only an end-of-file byte that also yields a record result gives two results,
// and the input stalls until the first has gone. A stalled receiver holds the
// result register; in_stall_o rises once the register cannot drain this cycle.
// After reset the parser waits for a key length and no result is pending.
`default_nettype none

module kv_record_vlq_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_file_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       payload_byte_o,
  output logic             record_done_o,
  output logic [31:0]      key_length_o,
  output logic [31:0]      value_length_o,
  output logic [1:0]       status_o,
  output logic             final_res_o
);

  logic            free;
  logic            accept;
  kvd_pkg::pair_t  pair;

  // An input transfer happens whenever the result register can take its output.
  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  kvd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_file_i (end_of_file_i),
    .pair_o        (pair)
  );

  kvd_out_buf u_out_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .pair_i         (pair),
    .free_o         (free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .record_done_o  (record_done_o),
    .key_length_o   (key_length_o),
    .value_length_o (value_length_o),
    .status_o       (status_o),
    .final_res_o    (final_res_o)
  );

endmodule

`default_nettype wire
